// ===== design/ilt_pkg.sv =====
package ilt_pkg;

    localparam int POS_BITS = 16;
    localparam int OUT_POS_W = 16;

    typedef logic [POS_BITS-1:0]  t_pos;
    typedef logic [OUT_POS_W-1:0] t_opos;

    localparam t_pos POS_MAX = '1;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_EQUAL = 8'h3d;
    localparam logic [7:0] CH_LBRK  = 8'h5b;
    localparam logic [7:0] CH_RBRK  = 8'h5d;

    typedef enum logic [2:0] {
        CLS_ZERO,
        CLS_NEWLINE,
        CLS_HASH,
        CLS_EQUAL,
        CLS_LBRACK,
        CLS_RBRACK,
        CLS_BLANK,
        CLS_OTHER
    } t_cls;

    typedef enum logic [1:0] {
        KIND_BLANK   = 2'd0,
        KIND_SECTION = 2'd1,
        KIND_KEYVAL  = 2'd2,
        KIND_ILLEGAL = 2'd3
    } t_kind;

    // one classified byte with its position
    typedef struct packed {
        t_cls cls;
        t_pos pos;
        t_pos pos_inc;
        logic at_max;
    } t_tok;

    typedef struct packed {
        t_kind kind;
        t_opos name_start;
        t_opos name_end;
        t_opos value_start;
        t_opos value_end;
        logic  end_of_text;
        logic  too_long;
    } t_res;

    function automatic t_opos to_opos(t_pos p);
        logic [31:0] w;
        w = 32'(p);
        return w[OUT_POS_W-1:0];
    endfunction

endpackage

// ===== design/ilt_front.sv =====
module ilt_front
    import ilt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_text_byte,
    output t_tok       o_tok
);

    t_pos r_pos;
    t_pos n_pos;
    t_cls cls;

    always_comb begin
        unique case (i_text_byte)
            CH_NUL:                 cls = CLS_ZERO;
            CH_NL:                  cls = CLS_NEWLINE;
            CH_HASH:                cls = CLS_HASH;
            CH_EQUAL:               cls = CLS_EQUAL;
            CH_LBRK:                cls = CLS_LBRACK;
            CH_RBRK:                cls = CLS_RBRACK;
            CH_SPACE, CH_TAB, CH_CR: cls = CLS_BLANK;
            default:                cls = CLS_OTHER;
        endcase
    end

    // position saturates at its maximum, restarts after the terminating zero
    always_comb begin
        n_pos = r_pos;
        if (i_accept) begin
            if (cls == CLS_ZERO) begin
                n_pos = '0;
            end else if (r_pos != POS_MAX) begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    always_comb begin
        o_tok.cls     = cls;
        o_tok.pos     = r_pos;
        o_tok.at_max  = (r_pos == POS_MAX);
        o_tok.pos_inc = (r_pos == POS_MAX) ? POS_MAX : r_pos + 1'b1;
    end

endmodule

// ===== design/ilt_tok_q.sv =====
module ilt_tok_q
    import ilt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_tok i_wdata,
    output logic o_full,
    input  logic i_rd,
    output t_tok o_rdata,
    output logic o_empty
);

    t_tok       r_mem [0:1];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_wr) begin
                r_wp <= ~r_wp;
            end
            if (i_rd) begin
                r_rp <= ~r_rp;
            end
            unique case ({i_wr, i_rd})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[r_rp];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);

endmodule

// ===== design/ilt_back.sv =====
module ilt_back
    import ilt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_take,
    input  t_tok i_tok,
    output logic o_res_valid,
    output t_res o_res
);

    logic r_in_comment, n_in_comment;
    logic r_content,    n_content;
    logic r_section,    n_section;
    logic r_closed,     n_closed;
    logic r_equal,      n_equal;
    logic r_drop,       n_drop;
    logic r_ovf,        n_ovf;
    t_pos r_ns, n_ns;
    t_pos r_ne, n_ne;
    t_pos r_vs, n_vs;
    t_pos r_ve, n_ve;
    t_pos r_lnb, n_lnb;

    always_comb begin
        t_pos  cur;
        t_pos  inc;
        t_kind kind;
        logic  is_zero;

        n_in_comment = r_in_comment;
        n_content    = r_content;
        n_section    = r_section;
        n_closed     = r_closed;
        n_equal      = r_equal;
        n_drop       = r_drop;
        n_ovf        = r_ovf;
        n_ns         = r_ns;
        n_ne         = r_ne;
        n_vs         = r_vs;
        n_ve         = r_ve;
        n_lnb        = r_lnb;
        cur          = i_tok.pos;
        inc          = i_tok.pos_inc;
        is_zero      = (i_tok.cls == CLS_ZERO);
        kind         = KIND_BLANK;
        o_res_valid  = 1'b0;

        if (i_take) begin
            if (i_tok.at_max) begin
                n_ovf = 1'b1;
            end

            if (i_tok.cls == CLS_ZERO || i_tok.cls == CLS_NEWLINE) begin
                if (!r_drop) begin
                    // empty pending span takes the terminator position
                    if (!r_in_comment && r_content) begin
                        if (r_section) begin
                            if (!r_closed && r_ns == r_ne) begin
                                n_ns = cur;
                                n_ne = cur;
                            end
                        end else if (r_equal && r_vs == r_ve) begin
                            n_vs = cur;
                            n_ve = cur;
                        end
                    end
                    if (!r_content) begin
                        kind = KIND_BLANK;
                    end else if (r_section) begin
                        kind = KIND_SECTION;
                    end else if (r_equal) begin
                        kind = KIND_KEYVAL;
                    end else begin
                        kind = KIND_ILLEGAL;
                    end
                    o_res_valid = 1'b1;
                end else if (is_zero) begin
                    kind        = KIND_BLANK;
                    o_res_valid = 1'b1;
                end
            end else if (!r_drop && !r_in_comment) begin
                if (i_tok.cls == CLS_HASH) begin
                    if (r_content) begin
                        if (r_section) begin
                            if (!r_closed && r_ns == r_ne) begin
                                n_ns = cur;
                                n_ne = cur;
                            end
                        end else if (r_equal && r_vs == r_ve) begin
                            n_vs = cur;
                            n_ve = cur;
                        end
                    end
                    n_in_comment = 1'b1;
                end else if (!r_content) begin
                    if (i_tok.cls != CLS_BLANK) begin
                        n_content = 1'b1;
                        if (i_tok.cls == CLS_LBRACK) begin
                            n_section = 1'b1;
                        end else if (i_tok.cls == CLS_EQUAL) begin
                            // key is empty: lnb is still zero here
                            n_ns    = cur;
                            n_ne    = cur;
                            n_lnb   = inc;
                            n_equal = 1'b1;
                            n_vs    = '0;
                            n_ve    = '0;
                        end else begin
                            n_ns  = cur;
                            n_lnb = inc;
                        end
                    end
                end else if (r_section) begin
                    if (!r_closed && i_tok.cls != CLS_BLANK) begin
                        if (i_tok.cls == CLS_RBRACK) begin
                            n_closed = 1'b1;
                            if (r_ns == r_ne) begin
                                n_ns = cur;
                                n_ne = cur;
                            end
                        end else begin
                            if (r_ns == r_ne) begin
                                n_ns = cur;
                            end
                            n_ne = inc;
                        end
                    end
                end else if (i_tok.cls != CLS_BLANK) begin
                    if (i_tok.cls == CLS_EQUAL) begin
                        // split at the last '='
                        if (r_lnb == '0) begin
                            n_ns = cur;
                            n_ne = cur;
                        end else begin
                            n_ne = r_lnb;
                        end
                        n_lnb   = inc;
                        n_equal = 1'b1;
                        n_vs    = '0;
                        n_ve    = '0;
                    end else begin
                        n_lnb = inc;
                        if (r_equal) begin
                            if (r_vs == r_ve) begin
                                n_vs = cur;
                            end
                            n_ve = inc;
                        end
                    end
                end
            end
        end

        o_res.kind        = kind;
        o_res.name_start  = '0;
        o_res.name_end    = '0;
        o_res.value_start = '0;
        o_res.value_end   = '0;
        o_res.end_of_text = is_zero;
        o_res.too_long    = n_ovf;
        if (kind == KIND_SECTION || kind == KIND_KEYVAL) begin
            o_res.name_start = to_opos(n_ns);
            o_res.name_end   = to_opos(n_ne);
        end
        if (kind == KIND_KEYVAL) begin
            o_res.value_start = to_opos(n_vs);
            o_res.value_end   = to_opos(n_ve);
        end

        // line state clears after every result, everything after end of text
        if (o_res_valid) begin
            n_in_comment = 1'b0;
            n_content    = 1'b0;
            n_section    = 1'b0;
            n_closed     = 1'b0;
            n_equal      = 1'b0;
            n_ns         = '0;
            n_ne         = '0;
            n_vs         = '0;
            n_ve         = '0;
            n_lnb        = '0;
            if (is_zero) begin
                n_drop = 1'b0;
                n_ovf  = 1'b0;
            end else if (kind == KIND_ILLEGAL) begin
                n_drop = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_comment <= 1'b0;
            r_content    <= 1'b0;
            r_section    <= 1'b0;
            r_closed     <= 1'b0;
            r_equal      <= 1'b0;
            r_drop       <= 1'b0;
            r_ovf        <= 1'b0;
            r_ns         <= '0;
            r_ne         <= '0;
            r_vs         <= '0;
            r_ve         <= '0;
            r_lnb        <= '0;
        end else begin
            r_in_comment <= n_in_comment;
            r_content    <= n_content;
            r_section    <= n_section;
            r_closed     <= n_closed;
            r_equal      <= n_equal;
            r_drop       <= n_drop;
            r_ovf        <= n_ovf;
            r_ns         <= n_ns;
            r_ne         <= n_ne;
            r_vs         <= n_vs;
            r_ve         <= n_ve;
            r_lnb        <= n_lnb;
        end
    end

endmodule

// ===== design/ilt_res_q.sv =====
module ilt_res_q
    import ilt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_res i_wdata,
    output logic o_full,
    input  logic i_rd,
    output t_res o_rdata,
    output logic o_empty
);

    t_res       r_mem [0:1];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_wr) begin
                r_wp <= ~r_wp;
            end
            if (i_rd) begin
                r_rp <= ~r_rp;
            end
            unique case ({i_wr, i_rd})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[r_rp];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);

endmodule

// ===== design/ini_line_tokenizer_top.sv =====
// ini line tokenizer: one text byte per word in, one result word per line out.
// input side is a queue: a byte is taken on a clock edge with push high and full
// low. a zero byte ends the text and resets all positions for the next text.
// output side is a queue too: the oldest result sits on the o_ ports while empty
// is low and leaves on an edge with pop high.
// each newline or zero byte not dropped gives one result (line kind, trimmed
// name and value spans as absolute byte positions, end_of_text, too_long);
// bytes after an illegal line, newlines too, are dropped up to the zero byte.
// throughput is one byte per cycle while the result queue has room; the parser
// register update is the per-byte step. a terminator is registered in the
// byte queue, then its result in the result queue. a front stage classifies
// and numbers bytes into a two-word queue; the back parser drains it into a
// two-word result queue. when the receiver stalls, the result queue fills,
// the parser halts and full rises once the byte queue holds two words; nothing
// is lost. synchronous reset clears positions, parser state and both queues.
module ini_line_tokenizer_top
    import ilt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_text_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_line_kind,
    output logic [15:0] o_name_start,
    output logic [15:0] o_name_end,
    output logic [15:0] o_value_start,
    output logic [15:0] o_value_end,
    output logic        o_end_of_text,
    output logic        o_too_long
);

    t_tok tok_in;
    t_tok tok_out;
    logic tq_full;
    logic tq_empty;
    logic in_accept;
    logic take;
    logic res_valid;
    t_res res_in;
    t_res res_out;
    logic rq_full;
    logic rq_empty;
    logic out_accept;

    assign in_accept  = push && !tq_full;
    assign out_accept = pop && !rq_empty;
    // parser moves only when a result word would have room
    assign take       = !tq_empty && (!rq_full || out_accept);

    ilt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_text_byte (i_text_byte),
        .o_tok       (tok_in)
    );

    ilt_tok_q u_tok_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (in_accept),
        .i_wdata (tok_in),
        .o_full  (tq_full),
        .i_rd    (take),
        .o_rdata (tok_out),
        .o_empty (tq_empty)
    );

    ilt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_tok       (tok_out),
        .o_res_valid (res_valid),
        .o_res       (res_in)
    );

    ilt_res_q u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_valid),
        .i_wdata (res_in),
        .o_full  (rq_full),
        .i_rd    (out_accept),
        .o_rdata (res_out),
        .o_empty (rq_empty)
    );

    assign full          = tq_full;
    assign empty         = rq_empty;
    assign o_line_kind   = res_out.kind;
    assign o_name_start  = res_out.name_start;
    assign o_name_end    = res_out.name_end;
    assign o_value_start = res_out.value_start;
    assign o_value_end   = res_out.value_end;
    assign o_end_of_text = res_out.end_of_text;
    assign o_too_long    = res_out.too_long;

endmodule

// ===== verif/tb_ini_line_tokenizer_top.sv =====
`timescale 1ns / 1ps

module tb_ini_line_tokenizer_top;
    import ilt_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 4;
    localparam int MAX_GAP        = 5;
    localparam int HOLD_CYCLES    = 64;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_BYTES   = 580;
    localparam int REPORT_LIMIT   = 10;

    class line_span_scoreboard;
        t_pos pos;
        bit   in_comment;
        bit   content_started;
        bit   section_line;
        bit   section_closed;
        bit   equal_seen;
        bit   dropping;
        bit   overflowed;
        t_pos name_s;
        t_pos name_e;
        t_pos val_s;
        t_pos val_e;
        t_pos last_nb;
        t_res expected_lines[$];
        int   errors;
        int   n_bytes;
        int   n_checked;
        int   kind_count[4];

        function new();
            restart_text();
            errors = 0;
            n_bytes = 0;
            n_checked = 0;
            kind_count = '{default: 0};
        endfunction

        function t_pos next_pos(t_pos x);
            return (x == POS_MAX) ? POS_MAX : t_pos'(x + 1'b1);
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == CH_SPACE || c == CH_TAB || c == CH_CR;
        endfunction

        function void clear_line();
            in_comment = 0;
            content_started = 0;
            section_line = 0;
            section_closed = 0;
            equal_seen = 0;
            name_s = '0;
            name_e = '0;
            val_s = '0;
            val_e = '0;
            last_nb = '0;
        endfunction

        function void restart_text();
            clear_line();
            pos = '0;
            dropping = 0;
            overflowed = 0;
        endfunction

        // empty spans still open take the closing position
        function void close_content(t_pos at);
            if (!content_started)
                return;
            if (section_line) begin
                if (!section_closed && name_s == name_e) begin
                    name_s = at;
                    name_e = at;
                end
            end else if (equal_seen && val_s == val_e) begin
                val_s = at;
                val_e = at;
            end
        endfunction

        function void take_equal(t_pos at);
            if (last_nb == '0) begin
                name_s = at;
                name_e = at;
            end else begin
                name_e = last_nb;
            end
            last_nb = next_pos(at);
            equal_seen = 1;
            val_s = '0;
            val_e = '0;
        endfunction

        function t_res make_line(t_kind kind, bit eot);
            t_res r;
            r = '0;
            r.kind = kind;
            if (kind == KIND_SECTION || kind == KIND_KEYVAL) begin
                r.name_start = to_opos(name_s);
                r.name_end   = to_opos(name_e);
            end
            if (kind == KIND_KEYVAL) begin
                r.value_start = to_opos(val_s);
                r.value_end   = to_opos(val_e);
            end
            r.end_of_text = eot;
            r.too_long    = overflowed;
            return r;
        endfunction

        function void take_byte(logic [7:0] c);
            t_pos  cur;
            t_kind kind;
            cur = pos;
            n_bytes++;
            if (cur == POS_MAX)
                overflowed = 1;
            else
                pos = t_pos'(cur + 1'b1);

            if (c == CH_NUL || c == CH_NL) begin
                if (dropping) begin
                    if (c == CH_NUL) begin
                        expected_lines.push_back(make_line(KIND_BLANK, 1'b1));
                        restart_text();
                    end
                    return;
                end
                if (!in_comment)
                    close_content(cur);
                if (!content_started)
                    kind = KIND_BLANK;
                else if (section_line)
                    kind = KIND_SECTION;
                else if (equal_seen)
                    kind = KIND_KEYVAL;
                else
                    kind = KIND_ILLEGAL;
                expected_lines.push_back(make_line(kind, c == CH_NUL));
                if (c == CH_NUL) begin
                    restart_text();
                end else begin
                    clear_line();
                    dropping = (kind == KIND_ILLEGAL);
                end
                return;
            end

            if (dropping || in_comment)
                return;

            if (c == CH_HASH) begin
                close_content(cur);
                in_comment = 1;
            end else if (!content_started) begin
                if (!is_blank(c)) begin
                    content_started = 1;
                    if (c == CH_LBRK) begin
                        section_line = 1;
                    end else begin
                        name_s = cur;
                        if (c == CH_EQUAL)
                            take_equal(cur);
                        else
                            last_nb = next_pos(cur);
                    end
                end
            end else if (section_line) begin
                if (section_closed || is_blank(c)) begin
                    // bytes after the closing bracket and blanks change nothing
                end else if (c == CH_RBRK) begin
                    section_closed = 1;
                    if (name_s == name_e) begin
                        name_s = cur;
                        name_e = cur;
                    end
                end else begin
                    if (name_s == name_e)
                        name_s = cur;
                    name_e = next_pos(cur);
                end
            end else if (!is_blank(c)) begin
                if (c == CH_EQUAL) begin
                    take_equal(cur);
                end else begin
                    last_nb = next_pos(cur);
                    if (equal_seen) begin
                        if (val_s == val_e)
                            val_s = cur;
                        val_e = next_pos(cur);
                    end
                end
            end
        endfunction

        function void check_line(t_res got);
            t_res want;
            if (expected_lines.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("%0t: result word with nothing expected", $realtime);
                    $display("  actual:   kind %0d name %h..%h value %h..%h eot %b long %b",
                             got.kind, got.name_start, got.name_end,
                             got.value_start, got.value_end, got.end_of_text, got.too_long);
                end
                return;
            end
            want = expected_lines.pop_front();
            n_checked++;
            kind_count[int'(want.kind)]++;
            if (got.kind !== want.kind || got.name_start !== want.name_start ||
                got.name_end !== want.name_end || got.value_start !== want.value_start ||
                got.value_end !== want.value_end || got.end_of_text !== want.end_of_text ||
                got.too_long !== want.too_long) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("%0t: line %0d mismatch", $realtime, n_checked);
                    $display("  expected: kind %0d name %h..%h value %h..%h eot %b long %b",
                             want.kind, want.name_start, want.name_end,
                             want.value_start, want.value_end, want.end_of_text, want.too_long);
                    $display("  actual:   kind %0d name %h..%h value %h..%h eot %b long %b",
                             got.kind, got.name_start, got.name_end,
                             got.value_start, got.value_end, got.end_of_text, got.too_long);
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_text_byte = 8'h00;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  o_line_kind;
    logic [15:0] o_name_start;
    logic [15:0] o_name_end;
    logic [15:0] o_value_start;
    logic [15:0] o_value_end;
    logic        o_end_of_text;
    logic        o_too_long;

    line_span_scoreboard sb;
    logic [7:0] byte_q[$];
    bit         hold_off = 1'b0;
    int         idle_cycles = 0;
    int         n_texts = 0;

    ini_line_tokenizer_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_text_byte   (i_text_byte),
        .empty         (empty),
        .pop           (pop),
        .o_line_kind   (o_line_kind),
        .o_name_start  (o_name_start),
        .o_name_end    (o_name_end),
        .o_value_start (o_value_start),
        .o_value_end   (o_value_end),
        .o_end_of_text (o_end_of_text),
        .o_too_long    (o_too_long)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ini_line_tokenizer_top test failed");
            $finish;
        end
    end

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 2))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 7))
            0:       return 8'($urandom_range(128, 255));
            1:       return 8'($urandom_range(48, 57));
            2:       return ($urandom_range(0, 1) != 0) ? CH_LBRK : CH_RBRK;
            default: return 8'($urandom_range(97, 122));
        endcase
    endfunction

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            byte_q.push_back(8'(s[i]));
    endtask

    task automatic add_blanks(input int max_n);
        repeat ($urandom_range(0, max_n)) byte_q.push_back(pick_blank());
    endtask

    task automatic add_word(input int min_n, input int max_n);
        repeat ($urandom_range(min_n, max_n)) byte_q.push_back(pick_char());
    endtask

    task automatic add_line();
        case ($urandom_range(0, 9))
            0: add_blanks(3);
            1: begin
                add_blanks(2);
                byte_q.push_back(CH_HASH);
                add_word(0, 4);
            end
            2, 3: begin
                add_blanks(2);
                byte_q.push_back(CH_LBRK);
                add_blanks(2);
                add_word(0, 4);
                add_blanks(1);
                if ($urandom_range(0, 3) != 0)
                    byte_q.push_back(CH_RBRK);
                add_blanks(1);
                add_word(0, 2);
                if ($urandom_range(0, 3) == 0)
                    byte_q.push_back(CH_HASH);
            end
            4, 5, 6, 8: begin
                add_blanks(2);
                add_word(0, 4);
                repeat ($urandom_range(1, 2)) begin
                    add_blanks(2);
                    byte_q.push_back(CH_EQUAL);
                    add_blanks(2);
                    add_word(0, 4);
                    if ($urandom_range(0, 2) == 0) begin
                        byte_q.push_back(pick_blank());
                        add_word(1, 3);
                    end
                end
                add_blanks(2);
                if ($urandom_range(0, 3) == 0) begin
                    byte_q.push_back(CH_HASH);
                    add_word(0, 3);
                end
            end
            7: begin
                add_blanks(2);
                add_word(1, 5);
                add_blanks(2);
            end
            default: begin
                // raw noise, a zero now and then cuts the text short
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(0, 40) == 0)
                        byte_q.push_back(CH_NUL);
                    else
                        byte_q.push_back(8'($urandom_range(1, 255)));
                end
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b, input int gap);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push <= 1'b1;
        i_text_byte <= b;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        sb.take_byte(b);
        if (b == CH_NUL)
            n_texts++;
        @(negedge i_clk);
    endtask

    task automatic send_queue(input bit no_gap);
        while (byte_q.size() != 0)
            send_byte(byte_q.pop_front(), no_gap ? 0 : $urandom_range(0, MAX_GAP));
    endtask

    // receiver holds off while a burst of newlines backs the block up
    task automatic send_burst();
        hold_off = 1'b1;
        repeat (16) byte_q.push_back(CH_NL);
        add_str("k=v\n");
        byte_q.push_back(CH_NUL);
        send_queue(1'b1);
    endtask

    initial begin : receiver
        t_res got;
        int   gap;
        int   run_left;
        bit   fast;
        run_left = 0;
        fast = 0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (run_left == 0) begin
                fast = ($urandom_range(0, 2) == 0);
                run_left = $urandom_range(8, 40);
            end
            run_left--;
            gap = fast ? 0 : $urandom_range(0, MAX_GAP);
            if (hold_off) begin
                gap = HOLD_CYCLES;
                hold_off = 1'b0;
            end
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty)
                @(posedge i_clk);
            got.kind        = t_kind'(o_line_kind);
            got.name_start  = o_name_start;
            got.name_end    = o_name_end;
            got.value_start = o_value_start;
            got.value_end   = o_value_end;
            got.end_of_text = o_end_of_text;
            got.too_long    = o_too_long;
            sb.check_line(got);
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        int  random_sent;
        bit  pressed;
        sb = new();
        random_sent = 0;
        pressed = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed lines
        add_str("\n [ a b ] x\nk=v\n=\na=b= c # x\nk = #\n[]\n\t[ab \n#c=d\nzz\nq=1\n");
        byte_q.push_back(CH_NUL);
        byte_q.push_back(CH_NUL);
        byte_q.push_back(8'hFF);
        add_str(" \t\r=");
        byte_q.push_back(8'h80);
        byte_q.push_back(CH_NUL);
        add_str("#x");
        byte_q.push_back(CH_NUL);
        add_str("zz");
        byte_q.push_back(CH_NUL);
        send_queue(1'b0);

        send_burst();

        while (random_sent < RANDOM_BYTES) begin
            if (!pressed && random_sent > RANDOM_BYTES / 2) begin
                send_burst();
                pressed = 1;
            end
            repeat ($urandom_range(1, 6)) begin
                add_line();
                if ($urandom_range(0, 5) != 0)
                    byte_q.push_back(CH_NL);
            end
            byte_q.push_back(CH_NUL);
            random_sent += byte_q.size();
            send_queue($urandom_range(0, 3) == 0);
        end
        push <= 1'b0;

        while (sb.expected_lines.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run: %0d bytes in %0d texts, %0d lines checked, two stalled newline bursts",
                 sb.n_bytes, n_texts, sb.n_checked);
        $display("kinds seen: blank %0d, section %0d, key/value %0d, illegal %0d; errors %0d",
                 sb.kind_count[0], sb.kind_count[1], sb.kind_count[2], sb.kind_count[3],
                 sb.errors);
        if (sb.errors == 0)
            $display("ini_line_tokenizer_top test passed");
        else
            $display("ini_line_tokenizer_top test failed");
        $finish;
    end

endmodule

// ===== ini_line_tokenizer_top.f =====
design/ilt_pkg.sv
design/ilt_front.sv
design/ilt_tok_q.sv
design/ilt_back.sv
design/ilt_res_q.sv
design/ini_line_tokenizer_top.sv
verif/tb_ini_line_tokenizer_top.sv
